FILE: rtl/core/plhl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plhl_pkg: shared constants and functions of the height lookup
// Field widths, status and function codes, datapath widths and the built-in
// terrain breakpoints loaded by the clearing pass after reset.
// ----------------------------------------------------------------------------
package plhl_pkg;

   // payload field widths
   localparam int COORD_W  = 16;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 2 * COORD_W;

   // default table depth and points in use after reset
   localparam int DEF_MAX_POINTS = 64;
   localparam int BOOT_POINTS    = 9;
   localparam logic [COUNT_W-1:0] RESET_POINTS_IN_USE = COUNT_W'(BOOT_POINTS);

   // datapath widths: differences, products, numerator of the division
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DEN_W  = COORD_W;

   // saturation limits as magnitudes
   localparam int SAT_POS_MAG = 32767;
   localparam int SAT_NEG_MAG = 32768;
   localparam logic [COORD_W-1:0] HEIGHT_MAX = 16'h7FFF;
   localparam logic [COORD_W-1:0] HEIGHT_MIN = 16'h8000;

   // function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SAT    = 2'd3;

   // built-in breakpoint for a table entry: y in the high half, x in the low
   function automatic logic [ENTRY_W-1:0] boot_entry(input int unsigned idx);
      logic [ENTRY_W-1:0] e;
      case (idx)
         0:       e = {16'd300,  16'd100};
         1:       e = {16'd100,  16'd700};
         2:       e = {16'd100,  16'd900};
         3:       e = {16'd300,  16'd1500};
         4:       e = {16'd400,  16'd2000};
         5:       e = {16'd200,  16'd3000};
         6:       e = {16'd300,  16'd4000};
         7:       e = {16'd200,  16'd6000};
         8:       e = {16'd10,   16'd7000};
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/plhl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plhl_if: request and response channels of the height lookup
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface plhl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic        [plhl_pkg::INDEX_W-1:0]  point_index;
   logic        [plhl_pkg::COORD_W-1:0]  point_x;
   logic signed [plhl_pkg::COORD_W-1:0]  point_y;
   logic        [plhl_pkg::COORD_W-1:0]  query_x;

   modport source (output valid, func, point_index, point_x, point_y, query_x,
                   input ready);
   modport sink   (input valid, func, point_index, point_x, point_y, query_x,
                   output ready);
endinterface

interface plhl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [plhl_pkg::COORD_W-1:0]  height;
   logic        [plhl_pkg::INDEX_W-1:0]  segment_end;
   logic        [plhl_pkg::STATUS_W-1:0] status;

   modport source (output valid, height, segment_end, status, input ready);
   modport sink   (input valid, height, segment_end, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/piecewise_linear_height_lookup_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_height_lookup_top: terrain height by linear interpolation
// Breakpoint table in one RAM; queries scan it and divide iteratively.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all MAX_POINTS addresses that
// loads the nine built-in breakpoints and zeroes the rest; req_bus.ready stays
// low meanwhile (CSR writes are taken). A write beat stores one breakpoint and
// yields an all-zero response. A query beat streams the first N table entries,
// N being the clamped points_in_use, through the single RAM read port (fewer
// when an early point ends the scan), then passes multiply, sum and magnitude,
// the bit-per-cycle divider (35 steps, then done) and the response register.
// A zero-length segment skips the divider. The next request is taken in the
// cycle after the response is loaded. One item is worked at a time; the
// response register lets the next request in while a response waits on
// rsp_bus.ready.
// ----------------------------------------------------------------------------
module piecewise_linear_height_lookup_top #(
   parameter int MAX_POINTS = plhl_pkg::DEF_MAX_POINTS
) (
   input  logic                         clock,
   input  logic                         reset,
   plhl_req_if.sink                     req_bus,
   plhl_rsp_if.source                   rsp_bus,
   input  logic                         csr_we,
   input  logic [plhl_pkg::COUNT_W-1:0] csr_wdata
);

   import plhl_pkg::*;

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_POINTS - 1);

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_ABS  = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_RESP = 3'd7;

   // control state
   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  init_addr_ff, init_addr_in;
   logic [ADDR_W-1:0]  scan_addr_ff, scan_addr_in;
   logic               issued_all_ff, issued_all_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]  data_idx_ff, data_idx_in;
   logic [ADDR_W-1:0]  last_ff, last_in;
   logic               write_ff, write_in;
   logic [COUNT_W-1:0] points_ff, points_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic        [COORD_W-1:0]  qx_ff;
   logic        [ENTRY_W-1:0]  prev_ff;
   logic signed [DIFF_W-1:0]   dx_ff, dy_ff, qd_ff, ay_ff;
   logic        [ADDR_W-1:0]   seg_ff;
   logic                       found_ff, zero_ff;
   logic signed [PROD_W-1:0]   p1_ff, p2_ff;
   logic signed [NUM_W-1:0]    sum_ff;
   logic                       qneg_ff;
   logic signed [COORD_W-1:0]  rsp_height_ff;
   logic        [INDEX_W-1:0]  rsp_seg_ff;
   logic        [STATUS_W-1:0] rsp_status_ff;

   // combinational
   logic               accept, wr_item, q_item, idx_ok, issue;
   logic               scan_data, scan_take, hit, scan_end, rsp_load;
   logic [31:0]        idx_wide, pts_wide, n_wide, last_wide;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata, rd_data;
   logic [COORD_W-1:0] cur_x, prev_x;
   logic               div_start, div_done;
   logic [NUM_W-1:0]   num_mag, quot;
   logic [DIFF_W-1:0]  den_full;
   logic               sat;
   logic [COORD_W-1:0] q_low;
   logic signed [COORD_W-1:0]  height_in;
   logic        [INDEX_W-1:0]  seg_out_in;
   logic        [STATUS_W-1:0] status_in;
   logic [31:0]        seg_wide;

   // request handshake
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept  = req_bus.valid && req_bus.ready;
   assign wr_item = accept && (req_bus.func == FUNC_WRITE);
   assign q_item  = accept && (req_bus.func == FUNC_QUERY);

   // write index check and clamp of points in use
   assign idx_wide  = 32'(req_bus.point_index);
   assign idx_ok    = (idx_wide < 32'(MAX_POINTS));
   assign pts_wide  = 32'(points_ff);
   assign n_wide    = (pts_wide < 32'd2) ? 32'd2 :
                      (pts_wide > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : pts_wide;
   assign last_wide = n_wide - 32'd1;

   // table RAM: clearing pass or breakpoint write
   assign ram_we    = (state_ff == S_INIT) || (wr_item && idx_ok);
   assign ram_waddr = (state_ff == S_INIT) ? init_addr_ff : idx_wide[ADDR_W-1:0];
   assign ram_wdata = (state_ff == S_INIT) ? boot_entry(32'(init_addr_ff)) :
                      {req_bus.point_y, req_bus.point_x};

   plhl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   // scan: reads stream out one per cycle, compare works on the registered read data
   assign issue     = (state_ff == S_SCAN) && !issued_all_ff;
   assign cur_x     = rd_data[COORD_W-1:0];
   assign prev_x    = prev_ff[COORD_W-1:0];
   assign scan_data = (state_ff == S_SCAN) && rd_vld_ff;
   assign scan_take = scan_data && (data_idx_ff != '0);
   assign hit       = (cur_x >= qx_ff);
   assign scan_end  = scan_take && (hit || (data_idx_ff == last_ff));

   // divider operands
   assign num_mag   = sum_ff[NUM_W-1] ? NUM_W'(-sum_ff) : NUM_W'(sum_ff);
   assign den_full  = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
   assign div_start = (state_ff == S_ABS) && !zero_ff;

   plhl_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_mag),
      .den   (den_full[DEN_W-1:0]),
      .done  (div_done),
      .quot  (quot)
   );

   // control next state
   always_comb begin
      state_in      = state_ff;
      init_addr_in  = init_addr_ff;
      scan_addr_in  = scan_addr_ff;
      issued_all_in = issued_all_ff;
      rd_vld_in     = issue;
      data_idx_in   = scan_addr_ff;
      last_in       = last_ff;
      write_in      = write_ff;
      points_in     = csr_we ? csr_wdata : points_ff;
      case (state_ff)
         S_INIT: begin
            init_addr_in = init_addr_ff + ADDR_W'(1);
            if (init_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (wr_item) begin
               write_in = 1'b1;
               state_in = S_RESP;
            end else if (q_item) begin
               write_in      = 1'b0;
               scan_addr_in  = '0;
               issued_all_in = 1'b0;
               last_in       = last_wide[ADDR_W-1:0];
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               if (scan_addr_ff == last_ff) begin
                  issued_all_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + ADDR_W'(1);
               end
            end
            if (scan_end) begin
               state_in = S_MUL;
            end
         end
         S_MUL:  state_in = S_SUM;
         S_SUM:  state_in = S_ABS;
         S_ABS:  state_in = zero_ff ? S_RESP : S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_addr_ff  <= '0;
         scan_addr_ff  <= '0;
         issued_all_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         data_idx_ff   <= '0;
         last_ff       <= '0;
         write_ff      <= 1'b0;
         points_ff     <= RESET_POINTS_IN_USE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_addr_ff  <= init_addr_in;
         scan_addr_ff  <= scan_addr_in;
         issued_all_ff <= issued_all_in;
         rd_vld_ff     <= rd_vld_in;
         data_idx_ff   <= data_idx_in;
         last_ff       <= last_in;
         write_ff      <= write_in;
         points_ff     <= points_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // query capture and segment endpoints
   always_ff @(posedge clock) begin
      if (q_item) begin
         qx_ff <= req_bus.query_x;
      end
      if (scan_data && !scan_end) begin
         prev_ff <= rd_data;
      end
      if (scan_end) begin
         dx_ff    <= $signed({1'b0, cur_x}) - $signed({1'b0, prev_x});
         dy_ff    <= $signed({rd_data[ENTRY_W-1], rd_data[ENTRY_W-1:COORD_W]}) -
                     $signed({prev_ff[ENTRY_W-1], prev_ff[ENTRY_W-1:COORD_W]});
         qd_ff    <= $signed({1'b0, qx_ff}) - $signed({1'b0, prev_x});
         ay_ff    <= $signed({prev_ff[ENTRY_W-1], prev_ff[ENTRY_W-1:COORD_W]});
         seg_ff   <= data_idx_ff;
         found_ff <= hit;
         zero_ff  <= (cur_x == prev_x);
      end
   end

   // products, numerator and quotient sign
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         p1_ff <= dy_ff * qd_ff;
         p2_ff <= ay_ff * dx_ff;
      end
      if (state_ff == S_SUM) begin
         sum_ff <= {p1_ff[PROD_W-1], p1_ff} + {p2_ff[PROD_W-1], p2_ff};
      end
      if (state_ff == S_ABS) begin
         qneg_ff <= sum_ff[NUM_W-1] ^ dx_ff[DIFF_W-1];
      end
   end

   // response fields: sign, saturation and status priority
   assign sat      = qneg_ff ? (quot > NUM_W'(SAT_NEG_MAG)) :
                               (quot > NUM_W'(SAT_POS_MAG));
   assign q_low    = quot[COORD_W-1:0];
   assign seg_wide = 32'(seg_ff);

   always_comb begin
      height_in  = '0;
      seg_out_in = '0;
      status_in  = STATUS_OK;
      if (!write_ff) begin
         seg_out_in = seg_wide[INDEX_W-1:0];
         if (zero_ff) begin
            height_in = ay_ff[COORD_W-1:0];
            status_in = STATUS_ZERO;
         end else if (sat) begin
            height_in = qneg_ff ? HEIGHT_MIN : HEIGHT_MAX;
            status_in = STATUS_SAT;
         end else begin
            height_in = qneg_ff ? (-q_low) : q_low;
            status_in = found_ff ? STATUS_OK : STATUS_BEYOND;
         end
      end
   end

   // response register
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_height_ff <= height_in;
         rsp_seg_ff    <= seg_out_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.height      = rsp_height_ff;
   assign rsp_bus.segment_end = rsp_seg_ff;
   assign rsp_bus.status      = rsp_status_ff;

endmodule
`default_nettype wire

FILE: rtl/core/plhl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plhl_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module plhl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/plhl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plhl_div: unsigned restoring divider
// One quotient bit per cycle, NUM_W steps; done pulses with quot valid.
// ----------------------------------------------------------------------------
module plhl_div #(
   parameter int NUM_W = plhl_pkg::NUM_W,
   parameter int DEN_W = plhl_pkg::DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quot_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_diff;
   logic             fits;

   // one restoring step: shift in next numerator bit, try subtract
   assign rem_shift = {rem_ff, quot_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = (rem_shift >= {1'b0, den_ff});

   // step counter and handshake
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // quotient shifts in from the right as the numerator shifts out
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= num;
         rem_ff  <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[NUM_W-2:0], fits};
         rem_ff  <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

FILE: rtl/core/plhl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plhl_checker: port-level checks of the height lookup
// Watches the channels of the top level; attached by bind below.
// ----------------------------------------------------------------------------
module plhl_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [plhl_pkg::COORD_W-1:0]  rsp_height,
   input wire [plhl_pkg::INDEX_W-1:0]  rsp_segment_end,
   input wire [plhl_pkg::STATUS_W-1:0] rsp_status
);

   import plhl_pkg::*;

   // clearing pass keeps requests out right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // one item in flight: ready drops after every accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in work");

   // saturated heights sit at a rail
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_SAT)) |->
      ((rsp_height == HEIGHT_MAX) || (rsp_height == HEIGHT_MIN)))
      else $error("saturated height off the rails");

   // any flagged status comes from a query, whose segment end is at least 1
   a_flag_segment: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_segment_end != '0))
      else $error("flagged response without a segment");

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_height) && $stable(rsp_segment_end) &&
       $stable(rsp_status)))
      else $error("response changed while stalled");

endmodule

bind piecewise_linear_height_lookup_top plhl_checker u_plhl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_height      (rsp_bus.height),
   .rsp_segment_end (rsp_bus.segment_end),
   .rsp_status      (rsp_bus.status)
);
`default_nettype wire

FILE: bench/tb_piecewise_linear_height_lookup_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_piecewise_linear_height_lookup_top: self-checking bench of the height lookup
// Sends breakpoint writes and height queries on the request channel. It keeps
// a shadow copy of the breakpoint table and of points_in_use, predicts every
// response beat and compares it field by field. A short directed table runs
// first, then random phases with different point counts and idle patterns.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_height_lookup_top;
   timeunit 1ns;
   timeprecision 1ps;

   import plhl_pkg::*;

   localparam int MAX_POINTS   = DEF_MAX_POINTS;
   localparam int N_DIRECTED   = 26;
   localparam int N_PHASES     = 8;
   localparam int PHASE_BEATS  = 116;
   localparam int DRAIN_CYCLES = 150;

   // built-in terrain after the clearing pass
   localparam int BOOT_X [BOOT_POINTS] = '{100, 700, 900, 1500, 2000, 3000, 4000, 6000, 7000};
   localparam int BOOT_Y [BOOT_POINTS] = '{300, 100, 100, 300, 400, 200, 300, 200, 10};

   // points_in_use per random phase, extremes and out-of-range values included
   localparam logic [COUNT_W-1:0] PHASE_COUNT [N_PHASES] = '{
      7'd9, 7'd64, 7'd2, 7'd40, 7'd127, 7'd0, 7'd17, 7'd1};

   typedef struct packed {
      logic signed [COORD_W-1:0]  height;
      logic        [INDEX_W-1:0]  segment_end;
      logic        [STATUS_W-1:0] status;
   } height_rsp_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [COUNT_W-1:0]        count;   // points_in_use for a CSR row
      logic [INDEX_W-1:0]        idx;
      logic [COORD_W-1:0]        px;
      logic signed [COORD_W-1:0] py;
      logic [COORD_W-1:0]        qx;
      logic                      typed;   // response given in the row
      height_rsp_type            rsp;
   } directed_row_type;

   localparam height_rsp_type WRITE_RSP = '{16'sd0, 6'd0, STATUS_OK};

   // directed stimulus; typed responses are the obvious ones
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      // reset table: below point 0, on points, flat segment, last point, far beyond
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd0, 1'b1, '{16'sd333, 6'd1, STATUS_OK}},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd100, 1'b1, '{16'sd300, 6'd1, STATUS_OK}},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd700, 1'b1, '{16'sd100, 6'd1, STATUS_OK}},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd800, 1'b1, '{16'sd100, 6'd2, STATUS_OK}},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd1200, 1'b1, '{16'sd200, 6'd3, STATUS_OK}},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd7000, 1'b1, '{16'sd10, 6'd8, STATUS_OK}},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd65535, 1'b1,
        '{-16'sd11111, 6'd8, STATUS_BEYOND}},
      // extreme write, then a repeated x to get a zero-length last segment
      '{ROW_WRITE, 7'd0, 6'd63, 16'd65535, 16'sh8000, 16'd0, 1'b1, WRITE_RSP},
      '{ROW_WRITE, 7'd0, 6'd9, 16'd7000, 16'sh7FFF, 16'd0, 1'b1, WRITE_RSP},
      '{ROW_CSR, 7'd10, 6'd0, 16'd0, 16'sd0, 16'd0, 1'b0, WRITE_RSP},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd7001, 1'b1, '{16'sd10, 6'd9, STATUS_ZERO}},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd6500, 1'b0, WRITE_RSP},
      // count above the table size clamps to all 64 points
      '{ROW_CSR, 7'd127, 6'd0, 16'd0, 16'sd0, 16'd0, 1'b0, WRITE_RSP},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd65535, 1'b1, '{HEIGHT_MIN, 6'd63, STATUS_OK}},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd65534, 1'b0, WRITE_RSP},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd7001, 1'b0, WRITE_RSP},
      // count below two clamps to one segment; steep segment saturates both ways
      '{ROW_CSR, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd0, 1'b0, WRITE_RSP},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd65535, 1'b1,
        '{-16'sd21511, 6'd1, STATUS_BEYOND}},
      '{ROW_WRITE, 7'd0, 6'd1, 16'd101, 16'sh7FFF, 16'd0, 1'b1, WRITE_RSP},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd65535, 1'b1, '{HEIGHT_MAX, 6'd1, STATUS_SAT}},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd0, 1'b1, '{HEIGHT_MIN, 6'd1, STATUS_SAT}},
      // zero-length first segment, then x falling
      '{ROW_CSR, 7'd1, 6'd0, 16'd0, 16'sd0, 16'd0, 1'b0, WRITE_RSP},
      '{ROW_WRITE, 7'd0, 6'd1, 16'd100, -16'sd5, 16'd0, 1'b1, WRITE_RSP},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd4242, 1'b1, '{16'sd300, 6'd1, STATUS_ZERO}},
      '{ROW_WRITE, 7'd0, 6'd1, 16'd40, 16'sh8000, 16'd0, 1'b1, WRITE_RSP},
      '{ROW_QUERY, 7'd0, 6'd0, 16'd0, 16'sd0, 16'd70, 1'b0, WRITE_RSP}
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_we;
   logic [COUNT_W-1:0] csr_wdata;

   plhl_req_if req_bus ();
   plhl_rsp_if rsp_bus ();

   piecewise_linear_height_lookup_top #(.MAX_POINTS(MAX_POINTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // shadow terrain table and register
   logic        [COORD_W-1:0] terrain_x [MAX_POINTS];
   logic signed [COORD_W-1:0] terrain_y [MAX_POINTS];
   logic        [COUNT_W-1:0] points_in_use;

   height_rsp_type pending_rsp [$];
   int errors        = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   function automatic int clamp_count(input logic [COUNT_W-1:0] count);
      int n;
      n = int'(count);
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      return n;
   endfunction

   // predicted response of one request beat; a write also updates the table
   function automatic height_rsp_type predict_lookup(input logic func,
         input logic [INDEX_W-1:0] idx, input logic [COORD_W-1:0] px,
         input logic signed [COORD_W-1:0] py, input logic [COORD_W-1:0] qx);
      height_rsp_type r;
      int             n;
      int             seg;
      bit             found;
      longint         ax, ay, dx, dy, h;
      r = '0;
      if (func == FUNC_WRITE) begin
         terrain_x[idx] = px;
         terrain_y[idx] = py;
         return r;
      end
      n     = clamp_count(points_in_use);
      seg   = n - 1;
      found = 1'b0;
      // first point from index 1 with x at or above the query
      for (int i = 1; i < n; i++) begin
         if (!found && terrain_x[i] >= qx) begin
            seg   = i;
            found = 1'b1;
         end
      end
      ax = longint'(terrain_x[seg-1]);
      ay = longint'(terrain_y[seg-1]);
      dx = longint'(terrain_x[seg]) - ax;
      dy = longint'(terrain_y[seg]) - ay;
      r.segment_end = INDEX_W'(seg);
      if (dx == 0) begin
         h        = ay;
         r.status = STATUS_ZERO;
      end else begin
         h = (dy * (longint'(qx) - ax) + ay * dx) / dx;
         if (h > 32767) begin
            h        = 32767;
            r.status = STATUS_SAT;
         end else if (h < -32768) begin
            h        = -32768;
            r.status = STATUS_SAT;
         end else if (!found) begin
            r.status = STATUS_BEYOND;
         end else begin
            r.status = STATUS_OK;
         end
      end
      r.height = COORD_W'(h);
      return r;
   endfunction

   // one request beat; valid is left high, an idle gap in the next call or a wait lowers it
   task automatic send_beat(input logic func, input logic [INDEX_W-1:0] idx,
         input logic [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
         input logic [COORD_W-1:0] qx, input bit typed, input height_rsp_type typed_rsp);
      height_rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= func;
      req_bus.point_index <= idx;
      req_bus.point_x     <= px;
      req_bus.point_y     <= py;
      req_bus.query_x     <= qx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      r = predict_lookup(func, idx, px, py, qx);
      pending_rsp.push_back(typed ? typed_rsp : r);
   endtask

   // hold the sender off until every response beat has come back
   task automatic wait_all_rsp();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic set_points_in_use(input logic [COUNT_W-1:0] count);
      wait_all_rsp();
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_we        <= 1'b0;
      points_in_use  = count;
   endtask

   // fresh terrain over the points in use: x mostly rising, repeats now and then
   task automatic rebuild_terrain(input int n);
      int                        x;
      int                        step_max;
      bit                        wide_y;
      logic signed [COORD_W-1:0] y;
      x        = $urandom_range(3000);
      step_max = (65535 - x) / n;
      wide_y   = ($urandom_range(3) == 0);
      for (int i = 0; i < n; i++) begin
         if (wide_y) y = COORD_W'($urandom);
         else y = COORD_W'($urandom_range(4000) - 2000);
         send_beat(FUNC_WRITE, INDEX_W'(i), COORD_W'(x), y, COORD_W'($urandom), 1'b0, '0);
         if ($urandom_range(19) != 0) x += $urandom_range(step_max, 1);
      end
   endtask

   // one random phase: rebuild, then mostly queries with some stray writes
   task automatic run_phase();
      int                   n;
      int                   sent;
      int                   pick;
      logic [COORD_W-1:0]   q;
      logic [INDEX_W-1:0]   idx;
      n = clamp_count(points_in_use);
      rebuild_terrain(n);
      sent = n;
      while (sent < PHASE_BEATS) begin
         if (sent == PHASE_BEATS / 2) wait_all_rsp();
         pick = $urandom_range(99);
         if (pick < 10) begin
            if ($urandom_range(9) < 7) idx = INDEX_W'($urandom_range(n - 1));
            else idx = INDEX_W'($urandom);
            send_beat(FUNC_WRITE, idx, COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), 1'b0, '0);
         end else begin
            if (pick < 40)
               q = terrain_x[$urandom_range(n - 1)] + COORD_W'($urandom_range(6)) - 16'd3;
            else if (pick < 60)
               q = COORD_W'($urandom);
            else if (pick < 68)
               q = ($urandom_range(1) == 0) ? 16'd0 : 16'hFFFF;
            else
               q = COORD_W'($urandom_range(int'(terrain_x[0]), int'(terrain_x[n-1])));
            send_beat(FUNC_QUERY, INDEX_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), q, 1'b0, '0);
         end
         sent++;
      end
   endtask

   // compare a response beat with the oldest prediction
   task automatic check_rsp();
      height_rsp_type want;
      if (pending_rsp.size() == 0) begin
         $display("%0t: unexpected response: expected none, actual height %0d seg %0d status %0d",
                  $time, rsp_bus.height, rsp_bus.segment_end, rsp_bus.status);
         errors++;
         return;
      end
      want = pending_rsp.pop_front();
      if (rsp_bus.height !== want.height) begin
         $display("%0t: height: expected %0d, actual %0d", $time, want.height, rsp_bus.height);
         errors++;
      end
      if (rsp_bus.segment_end !== want.segment_end) begin
         $display("%0t: segment_end: expected %0d, actual %0d",
                  $time, want.segment_end, rsp_bus.segment_end);
         errors++;
      end
      if (rsp_bus.status !== want.status) begin
         $display("%0t: status: expected %0d, actual %0d", $time, want.status, rsp_bus.status);
         errors++;
      end
   endtask

   // response side: sample the beat at the edge, then pick the next ready
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) check_rsp();
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // run limit
   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

   // stimulus
   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_wdata           <= RESET_POINTS_IN_USE;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= FUNC_WRITE;
      req_bus.point_index <= '0;
      req_bus.point_x     <= '0;
      req_bus.point_y     <= '0;
      req_bus.query_x     <= '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
         terrain_x[i] = '0;
         terrain_y[i] = '0;
         if (i < BOOT_POINTS) begin
            terrain_x[i] = COORD_W'(BOOT_X[i]);
            terrain_y[i] = COORD_W'(BOOT_Y[i]);
         end
      end
      points_in_use = RESET_POINTS_IN_USE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < N_DIRECTED; r++) begin
         if (DIRECTED[r].kind == ROW_CSR)
            set_points_in_use(DIRECTED[r].count);
         else
            send_beat((DIRECTED[r].kind == ROW_QUERY) ? FUNC_QUERY : FUNC_WRITE,
                      DIRECTED[r].idx, DIRECTED[r].px, DIRECTED[r].py, DIRECTED[r].qx,
                      DIRECTED[r].typed, DIRECTED[r].rsp);
      end

      // random phases: no gaps, sender idle, receiver stalls, both
      for (int p = 0; p < N_PHASES; p++) begin
         set_points_in_use(PHASE_COUNT[p]);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 73;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 73;
            end
            default: begin
               send_idle_pct = 33;
               rsp_stall_pct = 33;
            end
         endcase
         run_phase();
      end

      wait_all_rsp();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
